// ===== rtl/assert_macros.svh =====
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define CHK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define CHK_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/clip_pkg.sv =====
package clip_pkg;

    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_UC_A    = 8'd65;
    localparam logic [7:0] CH_UC_Z    = 8'd90;
    localparam logic [7:0] CH_LC_A    = 8'd97;
    localparam logic [7:0] CH_LC_Z    = 8'd122;
    localparam logic [7:0] CH_LC_X    = 8'd120;
    localparam logic [7:0] CH_UC_X    = 8'd88;
    localparam logic [7:0] CH_LC_B    = 8'd98;
    localparam logic [7:0] CH_UC_B    = 8'd66;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;

    localparam logic [5:0] NOT_DIGIT  = 6'd63;

    localparam logic [4:0] BASE_2     = 5'd2;
    localparam logic [4:0] BASE_8     = 5'd8;
    localparam logic [4:0] BASE_10    = 5'd10;
    localparam logic [4:0] BASE_16    = 5'd16;

    // Finished string, waiting for sign fix-up and delivery
    typedef struct packed {
        logic [31:0] acc;
        logic        neg;
        logic [4:0]  radix;
    } clip_result_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // '0'-'9' -> 0..9, letters of either case -> 10..35
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        digit_of = NOT_DIGIT;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            d = c - CH_ZERO;
            digit_of = d[5:0];
        end
        else if ((c >= CH_UC_A) && (c <= CH_UC_Z))
        begin
            d = c - CH_UC_A + 8'd10;
            digit_of = d[5:0];
        end
        else if ((c >= CH_LC_A) && (c <= CH_LC_Z))
        begin
            d = c - CH_LC_A + 8'd10;
            digit_of = d[5:0];
        end
    endfunction

endpackage

// ===== rtl/clip_parse.sv =====
`include "assert_macros.svh"

module clip_parse
    import clip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         pipe_valid,
    input  logic [7:0]   pipe_ch,
    input  logic         pipe_last,
    output logic         fin_valid,
    output clip_result_t fin
);

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_STOP   = 3'd4
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic         neg_reg, neg_next;
    logic [4:0]   base_reg, base_next;
    logic [31:0]  acc_reg, acc_next;
    logic         fin_valid_reg;
    clip_result_t fin_reg;

    logic [5:0]   d;
    logic         digit_ok;
    logic [31:0]  prod;
    logic [31:0]  acc_step;
    logic         step;

    logic         parse_idle;
    logic         base_ok;
    logic         pre_digits;

    assign step = advance && pipe_valid;

    always_comb
    begin
        d        = digit_of(pipe_ch);
        digit_ok = d < {1'b0, base_reg};
        case (base_reg)
            BASE_2:  prod = {acc_reg[30:0], 1'b0};
            BASE_8:  prod = {acc_reg[28:0], 3'b0};
            BASE_16: prod = {acc_reg[27:0], 4'b0};
            default: prod = {acc_reg[28:0], 3'b0} + {acc_reg[30:0], 1'b0};
        endcase
        acc_step = prod + {26'd0, d};

        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;

        case (phase_reg)
            PH_SKIP, PH_SIGN:
            begin
                if ((phase_reg == PH_SKIP) && is_ws(pipe_ch))
                begin
                    phase_next = PH_SKIP;
                end
                else if (pipe_ch == CH_MINUS)
                begin
                    neg_next   = ~neg_reg;
                    phase_next = PH_SIGN;
                end
                else if (pipe_ch == CH_ZERO)
                begin
                    base_next  = BASE_8;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    // accumulator is still zero here, so the first digit is the value
                    base_next = BASE_10;
                    if (d < {1'b0, BASE_10})
                    begin
                        acc_next   = {26'd0, d};
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
            end
            PH_ZERO:
            begin
                if ((pipe_ch == CH_LC_X) || (pipe_ch == CH_UC_X))
                begin
                    base_next  = BASE_16;
                    phase_next = PH_DIGITS;
                end
                else if ((pipe_ch == CH_LC_B) || (pipe_ch == CH_UC_B))
                begin
                    base_next  = BASE_2;
                    phase_next = PH_DIGITS;
                end
                else if (digit_ok)
                begin
                    acc_next   = acc_step;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            PH_DIGITS:
            begin
                if (digit_ok)
                begin
                    acc_next = acc_step;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            base_reg      <= BASE_10;
            acc_reg       <= 32'd0;
            fin_valid_reg <= 1'b0;
            fin_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                fin_valid_reg <= pipe_valid && pipe_last;
            end
            if (step)
            begin
                if (pipe_last)
                begin
                    // string done: back to the idle parse state
                    phase_reg     <= PH_SKIP;
                    neg_reg       <= 1'b0;
                    base_reg      <= BASE_10;
                    acc_reg       <= 32'd0;
                    fin_reg.acc   <= acc_next;
                    fin_reg.neg   <= neg_next;
                    fin_reg.radix <= base_next;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    base_reg  <= base_next;
                    acc_reg   <= acc_next;
                end
            end
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    assign parse_idle = (phase_reg == PH_SKIP) && (acc_reg == 32'd0) && !neg_reg
                        && (base_reg == BASE_10);
    assign base_ok    = (base_reg == BASE_2) || (base_reg == BASE_8)
                        || (base_reg == BASE_10) || (base_reg == BASE_16);
    assign pre_digits = (phase_reg == PH_SKIP) || (phase_reg == PH_SIGN);

    `CHK(a_restart_after_last, step && pipe_last |=> parse_idle, "parser not reset after string")
    `CHK(a_base_legal, base_ok, "illegal base")
    `CHK(a_acc_zero_before_digits, pre_digits |-> acc_reg == 32'd0, "accumulator set before digits")

endmodule

// ===== rtl/clip_out.sv =====
`include "assert_macros.svh"

module clip_out
    import clip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fin_valid,
    input  clip_result_t       fin,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [4:0]         radix
);

    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic [4:0]         radix_reg;
    logic               skid_full_reg;
    logic signed [31:0] skid_value_reg;
    logic [4:0]         skid_radix_reg;

    logic               arrive;
    logic               out_fire;
    logic signed [31:0] fixed_value;

    assign advance     = !skid_full_reg;
    assign arrive      = advance && fin_valid;
    assign out_fire    = out_valid_reg && !out_stall;
    assign fixed_value = fin.neg ? $signed(~fin.acc + 32'd1) : $signed(fin.acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_fire)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= arrive;
        end
        else if (arrive)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_fire)
            begin
                value_reg <= skid_value_reg;
                radix_reg <= skid_radix_reg;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (arrive)
            begin
                value_reg <= fixed_value;
                radix_reg <= fin.radix;
            end
        end
        else if (arrive)
        begin
            skid_value_reg <= fixed_value;
            skid_radix_reg <= fin.radix;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign radix     = radix_reg;

    `CHK_NEVER(a_skid_without_out, skid_full_reg && !out_valid_reg, "skid holds data while output is empty")
    `CHK(a_skid_keeps_valid, skid_full_reg && out_fire |=> out_valid_reg && !skid_full_reg, "skid transfer lost")

endmodule

// ===== rtl/c_integer_literal_parser.sv =====
// Channel  | Signals                        | Handshake
// ---------+--------------------------------+-------------------------------
// input    | ch[7:0], last                  | in_valid / in_stall
// output   | value[31:0] signed, radix[4:0] | out_valid / out_stall
//
// One character per cycle while in_stall is low; one result per string, on its last char.
// The final character passes the input register, then the parse step into the result register,
// then the sign fix-up into the output register, before out_valid rises.
// The parse step is a shift-add on the accumulator, done once per character.
// in_stall rises only when the output skid register is full.
// Reset is asynchronous, active low; it empties the pipe and clears the parser.
module c_integer_literal_parser
    import clip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [4:0]         radix
);

    logic         advance;
    logic         pipe_valid_reg;
    logic [7:0]   pipe_ch_reg;
    logic         pipe_last_reg;
    logic         fin_valid;
    clip_result_t fin;

    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            pipe_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            pipe_ch_reg   <= ch;
            pipe_last_reg <= last;
        end
    end

    clip_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .pipe_valid (pipe_valid_reg),
        .pipe_ch    (pipe_ch_reg),
        .pipe_last  (pipe_last_reg),
        .fin_valid  (fin_valid),
        .fin        (fin)
    );

    clip_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .radix     (radix)
    );

endmodule

// ===== verif/literal_checker.sv =====
`timescale 1ns / 100ps

module literal_checker
    import clip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] value,
    input  logic [4:0]         radix,
    output int                 mismatch_count,
    output int                 outstanding
);

    typedef enum logic [2:0] {
        SCAN_WS,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_t;

    typedef struct {
        logic [31:0] value;
        logic [4:0]  radix;
    } parsed_t;

    localparam logic [5:0] NO_WEIGHT = 6'd63;

    parsed_t     expected_values[$];
    scan_phase_t scan_phase;
    logic        negate;
    logic [4:0]  base;
    logic [31:0] acc;

    function automatic logic [5:0] char_weight(input logic [7:0] c);
        logic [7:0] w;
        w = {2'b00, NO_WEIGHT};
        if (c >= CH_ZERO && c <= CH_NINE)
            w = c - CH_ZERO;
        else if (c >= CH_UC_A && c <= CH_UC_Z)
            w = c - CH_UC_A + 8'd10;
        else if (c >= CH_LC_A && c <= CH_LC_Z)
            w = c - CH_LC_A + 8'd10;
        return w[5:0];
    endfunction

    task automatic clear_parser();
        scan_phase = SCAN_WS;
        negate = 1'b0;
        base = BASE_10;
        acc = 32'd0;
    endtask

    task automatic take_digit(input logic [7:0] c);
        logic [5:0] w;
        w = char_weight(c);
        if (w < {1'b0, base})
        begin
            acc = acc * {27'd0, base} + {26'd0, w};
            scan_phase = SCAN_DIGITS;
        end
        else
            scan_phase = SCAN_DONE;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic fin);
        parsed_t r;
        logic    blank;
        blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        if (scan_phase == SCAN_WS && blank)
            ;
        else if (scan_phase == SCAN_WS || scan_phase == SCAN_SIGN)
        begin
            if (c == CH_MINUS)
            begin
                negate = ~negate;
                scan_phase = SCAN_SIGN;
            end
            else if (c == CH_ZERO)
            begin
                base = BASE_8;
                scan_phase = SCAN_ZERO;
            end
            else
            begin
                base = BASE_10;
                take_digit(c);
            end
        end
        else if (scan_phase == SCAN_ZERO)
        begin
            if (c == CH_LC_X || c == CH_UC_X)
            begin
                base = BASE_16;
                scan_phase = SCAN_DIGITS;
            end
            else if (c == CH_LC_B || c == CH_UC_B)
            begin
                base = BASE_2;
                scan_phase = SCAN_DIGITS;
            end
            else
                take_digit(c);
        end
        else if (scan_phase == SCAN_DIGITS)
            take_digit(c);

        if (fin)
        begin
            r.value = negate ? (32'd0 - acc) : acc;
            r.radix = base;
            expected_values.push_back(r);
            clear_parser();
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        outstanding = 0;
        clear_parser();
    end

    always @(posedge clk or negedge rst_n)
    begin
        parsed_t e;
        if (!rst_n)
        begin
            clear_parser();
            expected_values.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_char(ch, last);
            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: result with none pending: value %0d radix %0d",
                             $time, value, radix);
                    mismatch_count++;
                end
                else
                begin
                    e = expected_values.pop_front();
                    if (value !== e.value)
                    begin
                        $display("%0t: value expected %0d actual %0d", $time,
                                 $signed(e.value), value);
                        mismatch_count++;
                    end
                    if (radix !== e.radix)
                    begin
                        $display("%0t: radix expected %0d actual %0d", $time,
                                 e.radix, radix);
                        mismatch_count++;
                    end
                end
            end
        end
        outstanding = expected_values.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import clip_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_CHARS  = 1550;
    localparam int IDLE_PCT      = 14;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         ch;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] value;
    logic [4:0]         radix;

    int                 mismatch_count;
    int                 outstanding;
    int                 cycle_count;
    int                 chars_sent;
    logic               calm;
    logic [7:0]         text_q[$];

    c_integer_literal_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .radix     (radix)
    );

    literal_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ch             (ch),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .radix          (radix),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // one character transfer; valid stays high across back-to-back transfers
    task automatic put_char(input logic [7:0] c, input logic fin);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        last <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            put_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(d - 10);
    endfunction

    // well-formed literal with random content, sometimes with a junk tail
    task automatic build_literal();
        int unsigned b;
        int unsigned n;
        int unsigned sel;
        b = 10;
        n = $urandom_range(3);
        repeat (n)
            text_q.push_back($urandom_range(4) == 0 ? CH_SPACE :
                             8'($urandom_range(CH_TAB, CH_CR)));
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                text_q.push_back(CH_MINUS);
        sel = $urandom_range(5);
        if (sel >= 2)
        begin
            text_q.push_back(CH_ZERO);
            b = 8;
            if (sel == 3)
            begin
                text_q.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
                b = 16;
            end
            else if (sel == 4)
            begin
                text_q.push_back($urandom_range(1) ? CH_LC_B : CH_UC_B);
                b = 2;
            end
        end
        n = ($urandom_range(7) == 0) ? $urandom_range(12, 36) : $urandom_range(12);
        repeat (n)
            text_q.push_back(digit_char($urandom_range(b - 1)));
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                text_q.push_back(8'($urandom_range(255)));
        if (text_q.size() == 0)
            text_q.push_back(CH_ZERO);
        chars_sent += text_q.size();
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 8))
            text_q.push_back(8'($urandom_range(255)));
        chars_sent += text_q.size();
    endtask

    task automatic directed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = 8'd0;
        last = 1'b0;
        calm = 1'b0;
        chars_sent = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone zero, bare prefixes, whitespace and sign handling, stop chars
        directed_text("0");
        directed_text("0x");
        directed_text("0B1");
        directed_text(" \t--z");
        directed_text("-- 5");
        directed_text("0789");
        text_q.push_back(CH_CR);
        send_text();
        text_q.push_back(8'd255);
        send_text();
        text_q.push_back(8'd0);
        send_text();
        directed_text("-0XfF");

        while (chars_sent < RANDOM_CHARS)
        begin
            calm = (chars_sent >= 500 && chars_sent < 800);
            if ($urandom_range(99) < 80)
                build_literal();
            else
                build_noise();
            send_text();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // let the checker take the final transfer before polling
        @(posedge clk);
        wait (outstanding == 0);
        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
